>>> src/cpo_pkg.sv
// ----------------------------------------------------------------------------
// cpo_pkg: shared types and constants for the complex phase block
// Fixed-point formats, the arctangent table and the word tag carried
// alongside the CORDIC data path.
// ----------------------------------------------------------------------------
package cpo_pkg;

  localparam int ANGLE_FRAC = 24;   // fractional bits inside the rotator
  localparam int OUT_FRAC   = 13;   // fractional bits of the result
  localparam int ZW         = 28;   // angle accumulator width
  localparam int PHASE_W    = 18;
  localparam int OFFSET_W   = 16;
  localparam int TABLE_LEN  = 24;
  localparam int IDX_W      = 5;

  localparam logic signed [ZW-1:0]      PI_Q24 = 28'sd52707179;
  localparam logic signed [PHASE_W-1:0] PI_Q13 = 18'sd25736;

  typedef struct packed {
    logic zero;   // both sample parts were zero
    logic last;
  } tag_t;

  // atan(2^-i) with 24 fractional bits
  function automatic logic signed [ZW-1:0] atan_q24(input logic [IDX_W-1:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:    a = 28'sd13176795;
      5'd1:    a = 28'sd7778716;
      5'd2:    a = 28'sd4110060;
      5'd3:    a = 28'sd2086331;
      5'd4:    a = 28'sd1047214;
      5'd5:    a = 28'sd524117;
      5'd6:    a = 28'sd262123;
      5'd7:    a = 28'sd131069;
      5'd8:    a = 28'sd65536;
      5'd9:    a = 28'sd32768;
      5'd10:   a = 28'sd16384;
      5'd11:   a = 28'sd8192;
      5'd12:   a = 28'sd4096;
      5'd13:   a = 28'sd2048;
      5'd14:   a = 28'sd1024;
      5'd15:   a = 28'sd512;
      5'd16:   a = 28'sd256;
      5'd17:   a = 28'sd128;
      5'd18:   a = 28'sd64;
      5'd19:   a = 28'sd32;
      5'd20:   a = 28'sd16;
      5'd21:   a = 28'sd8;
      5'd22:   a = 28'sd4;
      5'd23:   a = 28'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> src/cpo_sample_if.sv
// ----------------------------------------------------------------------------
// cpo_sample_if: complex sample channel
// Valid/ready channel carrying one complex sample and its last flag.
// ----------------------------------------------------------------------------
interface cpo_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] real_part;
  logic signed [SAMPLE_BITS-1:0] imag_part;
  logic                          last_in;

  modport source (output valid, real_part, imag_part, last_in, input ready);
  modport sink   (input valid, real_part, imag_part, last_in, output ready);
endinterface

>>> src/cpo_phase_if.sv
// ----------------------------------------------------------------------------
// cpo_phase_if: phase result channel
// Valid/ready channel carrying one phase word and its last flag.
// ----------------------------------------------------------------------------
interface cpo_phase_if
  import cpo_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [PHASE_W-1:0] phase;
  logic                      last_out;

  modport source (output valid, phase, last_out, input ready);
  modport sink   (input valid, phase, last_out, output ready);
endinterface

>>> src/complex_phase_with_offset.sv
// ----------------------------------------------------------------------------
// complex_phase_with_offset: phase of a complex sample plus start offset
// Pipelined CORDIC in vectoring mode; atan2(imag, real) + pi + offset.
// ----------------------------------------------------------------------------
// Takes one complex word per clock while the chain is not backed up and
// returns atan2(imag, real) + pi + phase_offset in radians, 13 fractional
// bits (pi = 25736), unwrapped, last_out copied from last_in; a zero sample
// gives pi + offset. The pipe is one input cell for the half-plane fold,
// one cell per micro-rotation and one output cell for rounding and the
// offset add. Every cell is registered, its ready only looks downstream when
// full, so bubbles collapse under back-pressure. phase_offset is to be
// written with cfg_we_i only while idle; the block does not enforce this.
module complex_phase_with_offset
  import cpo_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic signed [OFFSET_W-1:0] cfg_wdata_i,
  cpo_sample_if.sink                 sample_i,
  cpo_phase_if.source                phase_o
);

  localparam int XW = SAMPLE_BITS + ANGLE_FRAC + 3;

  logic signed [OFFSET_W-1:0] offset_q;

  logic                 valid_s [CORDIC_STAGES+1];
  logic                 ready_s [CORDIC_STAGES+1];
  logic signed [XW-1:0] x_s     [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_s     [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_s     [CORDIC_STAGES+1];
  tag_t                 tag_s   [CORDIC_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  cpo_prerot #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .XW          (XW)
  ) u_prerot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .real_i      (sample_i.real_part),
    .imag_i      (sample_i.imag_part),
    .last_i      (sample_i.last_in),
    .out_valid_o (valid_s[0]),
    .out_ready_i (ready_s[0]),
    .x_o         (x_s[0]),
    .y_o         (y_s[0]),
    .z_o         (z_s[0]),
    .tag_o       (tag_s[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    cpo_cell #(
      .XW    (XW),
      .STAGE (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_s[g]),
      .in_ready_o  (ready_s[g]),
      .x_i         (x_s[g]),
      .y_i         (y_s[g]),
      .z_i         (z_s[g]),
      .tag_i       (tag_s[g]),
      .out_valid_o (valid_s[g+1]),
      .out_ready_i (ready_s[g+1]),
      .x_o         (x_s[g+1]),
      .y_o         (y_s[g+1]),
      .z_o         (z_s[g+1]),
      .tag_o       (tag_s[g+1])
    );
  end

  cpo_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_s[CORDIC_STAGES]),
    .in_ready_o  (ready_s[CORDIC_STAGES]),
    .z_i         (z_s[CORDIC_STAGES]),
    .tag_i       (tag_s[CORDIC_STAGES]),
    .offset_i    (offset_q),
    .out_valid_o (phase_o.valid),
    .out_ready_i (phase_o.ready),
    .phase_o     (phase_o.phase),
    .last_o      (phase_o.last_out)
  );

  // the input only stalls when the output word is held by the sink
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> phase_o.valid && !phase_o.ready)
    else $error("input stalled without output back-pressure");

  // while the input stalls, the input cell and the last rotation cell both hold a word
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> valid_s[0] && valid_s[CORDIC_STAGES])
    else $error("input stalled with an empty cell in the chain");

endmodule

>>> src/cpo_prerot.sv
// ----------------------------------------------------------------------------
// cpo_prerot: input cell of the rotator chain
// Scales the sample, folds the left half-plane onto the right one and
// seeds the angle with +-pi for a left-half-plane sample, with zero otherwise.
// ----------------------------------------------------------------------------
module cpo_prerot
  import cpo_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int XW          = 43
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] real_i,
  input  logic signed [SAMPLE_BITS-1:0] imag_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [XW-1:0]          x_o,
  output logic signed [XW-1:0]          y_o,
  output logic signed [ZW-1:0]          z_o,
  output tag_t                          tag_o
);

  localparam int EXT_W = XW - SAMPLE_BITS - ANGLE_FRAC;

  logic                 valid_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d, x_sc, y_sc;
  logic signed [ZW-1:0] z_q, z_d;
  tag_t                 tag_q, tag_d;
  logic                 load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    x_sc = {{EXT_W{real_i[SAMPLE_BITS-1]}}, real_i, {ANGLE_FRAC{1'b0}}};
    y_sc = {{EXT_W{imag_i[SAMPLE_BITS-1]}}, imag_i, {ANGLE_FRAC{1'b0}}};
    tag_d.zero = (real_i == '0) && (imag_i == '0);
    tag_d.last = last_i;
    if (real_i[SAMPLE_BITS-1]) begin
      // left half-plane: rotate by pi, sign of pi follows the imaginary part
      x_d = -x_sc;
      y_d = -y_sc;
      z_d = imag_i[SAMPLE_BITS-1] ? -PI_Q24 : PI_Q24;
    end else begin
      x_d = x_sc;
      y_d = y_sc;
      z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      tag_q <= tag_d;
    end
  end

  assign out_valid_o = valid_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign z_o         = z_q;
  assign tag_o       = tag_q;

endmodule

>>> src/cpo_cell.sv
// ----------------------------------------------------------------------------
// cpo_cell: one CORDIC micro-rotation
// Rotates the vector towards the positive real axis by atan(2^-STAGE)
// and accumulates the angle; registered, with its own bubble-collapsing
// ready.
// ----------------------------------------------------------------------------
module cpo_cell
  import cpo_pkg::*;
#(
  parameter int XW    = 43,
  parameter int STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  tag_t                 tag_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output tag_t                 tag_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q24(IDX_W'(STAGE));

  logic                 valid_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d;
  tag_t                 tag_q;
  logic                 load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      tag_q <= tag_i;
    end
  end

  assign out_valid_o = valid_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign z_o         = z_q;
  assign tag_o       = tag_q;

endmodule

>>> src/cpo_post.sv
// ----------------------------------------------------------------------------
// cpo_post: output cell
// Rounds the angle to 13 fractional bits, clamps to +-pi (zero for a zero
// sample), adds pi and the start offset, and holds the word for the sink.
// ----------------------------------------------------------------------------
module cpo_post
  import cpo_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [ZW-1:0]       z_i,
  input  tag_t                       tag_i,
  input  logic signed [OFFSET_W-1:0] offset_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [PHASE_W-1:0]  phase_o,
  output logic                       last_o
);

  localparam int RND_SH = ANGLE_FRAC - OUT_FRAC;
  localparam int RW     = ZW + 1;

  logic                      valid_q;
  logic signed [PHASE_W-1:0] phase_q, phase_d, ang, ang_c, off_ext;
  logic signed [RW-1:0]      z_rnd;
  logic                      last_q;
  logic                      load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    z_rnd   = RW'(z_i) + (RW'(1) <<< (RND_SH - 1));
    ang     = PHASE_W'(z_rnd >>> RND_SH);
    off_ext = PHASE_W'(offset_i);
    if (tag_i.zero) begin
      ang_c = '0;
    end else if (ang > PI_Q13) begin
      ang_c = PI_Q13;
    end else if (ang < -PI_Q13) begin
      ang_c = -PI_Q13;
    end else begin
      ang_c = ang;
    end
    phase_d = ang_c + PI_Q13 + off_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      phase_q <= phase_d;
      last_q  <= tag_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign phase_o     = phase_q;
  assign last_o      = last_q;

  // zero sample gives exactly pi plus offset
  a_zero_pi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && tag_i.zero |=> phase_q == PI_Q13 + PHASE_W'($past(offset_i)))
    else $error("zero sample did not give pi plus offset");

  // clamped angle keeps the word within [offset, 2*pi + offset]
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (phase_q - PHASE_W'($past(offset_i)) >= 0) &&
             (phase_q - PHASE_W'($past(offset_i)) <= PI_Q13 + PI_Q13))
    else $error("phase outside clamped range");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for complex_phase_with_offset
// Streams complex samples through the CORDIC phase block across several
// start-offset settings and checks each phase word and its last flag against
// a bit-accurate vectoring CORDIC written here. Both channels idle at random,
// and the result side holds off for long spells so that the pipe backs up.
// ----------------------------------------------------------------------------
module tb_top
  import cpo_pkg::*;
();

  localparam int          STAGES         = 16;
  localparam int          PIPE_LATENCY   = STAGES + 2;
  localparam int          SQUEEZE_CYCLES = 400;
  localparam int          STALL_LIMIT    = 3000;
  localparam int          PRINT_CAP      = 200;
  localparam longint      HALF_TURN      = 25736;
  localparam longint      PI_FINE        = 52707179;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic signed [PHASE_W-1:0] phase;
    logic                      last;
  } phase_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic signed [OFFSET_W-1:0] cfg_wdata_i;

  cpo_sample_if #(.SAMPLE_BITS(16)) smp_if ();
  cpo_phase_if                      ph_if ();

  complex_phase_with_offset #(
    .SAMPLE_BITS  (16),
    .CORDIC_STAGES(STAGES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   (smp_if),
    .phase_o    (ph_if)
  );

  // atan(2^-i), 24 fractional bits
  longint atan_step [0:STAGES-1] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
  };

  sample_t            sample_pending[$];
  phase_word_t        phase_due[$];
  logic signed [15:0] offset_now;
  bit                 no_idle;
  bit                 sample_fire;
  int unsigned        send_gap;
  int unsigned        hold_left;
  int unsigned        press_requests;
  int unsigned        press_served;
  int unsigned        quiet_cycles;
  int unsigned        fail_count;
  phase_word_t        got_word;
  phase_word_t        due_word;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic signed [PHASE_W-1:0] expected_phase(
    input logic signed [15:0] re,
    input logic signed [15:0] im,
    input logic signed [15:0] offset
  );
    longint x, y, z, xs, ys, t, ph;
    if (re == 0 && im == 0) begin
      t = 0;
    end else begin
      x = longint'(re) * 64'sd16777216;
      y = longint'(im) * 64'sd16777216;
      z = 0;
      // left half-plane: fold by pi, sign taken from imag
      if (x < 0) begin
        z = (y >= 0) ? PI_FINE : -PI_FINE;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_step[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_step[i];
        end
      end
      t = (z + 1024) >>> 11;
      if (t > HALF_TURN) t = HALF_TURN;
      if (t < -HALF_TURN) t = -HALF_TURN;
    end
    ph = t + HALF_TURN + longint'(offset);
    return ph[PHASE_W-1:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic signed [15:0] pick_corner();
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.re   = 16'($urandom);
    s.im   = 16'($urandom);
    s.last = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 9))
      6: begin
        s.re = 16'(int'($urandom_range(0, 32)) - 16);
        s.im = 16'(int'($urandom_range(0, 32)) - 16);
      end
      7: begin
        if ($urandom_range(0, 1) == 0) s.re = '0;
        else s.im = '0;
      end
      8: begin
        s.re = pick_corner();
        s.im = pick_corner();
      end
      9: s.im = ($urandom_range(0, 1) == 0) ? s.re : -s.re;
      default: ;
    endcase
    return s;
  endfunction

  task automatic note_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  task automatic push_sample(input int re, input int im, input bit last);
    sample_t s;
    s.re   = 16'(re);
    s.im   = 16'(im);
    s.last = last;
    sample_pending.push_back(s);
  endtask

  // wait for the pipe to drain, then give it its latency again
  task automatic settle();
    while (sample_pending.size() != 0 || smp_if.valid || phase_due.size() != 0)
      @(negedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int offset, input int n, input bit quiet,
                           input bit squeeze);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 16'(offset);
    offset_now  = 16'(offset);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    no_idle = quiet;
    if (squeeze) press_requests++;
    push_sample(0, 0, 1'b0);
    for (int k = 0; k < n; k++) sample_pending.push_back(random_sample());
  endtask

  // sender: one word offered at a time, fresh word only once the last one went
  always @(negedge clk_i) begin
    if (rst_ni && (!smp_if.valid || sample_fire)) begin
      if (send_gap != 0) begin
        smp_if.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (sample_pending.size() != 0) begin
        smp_if.valid     <= 1'b1;
        smp_if.real_part <= sample_pending[0].re;
        smp_if.imag_part <= sample_pending[0].im;
        smp_if.last_in   <= sample_pending[0].last;
        void'(sample_pending.pop_front());
        send_gap <= no_idle ? 0 : pick_gap();
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus the occasional long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (press_served != press_requests) begin
        ph_if.ready  <= 1'b0;
        hold_left    <= SQUEEZE_CYCLES;
        press_served <= press_served + 1;
      end else if (hold_left != 0) begin
        ph_if.ready <= 1'b0;
        hold_left   <= hold_left - 1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        ph_if.ready <= 1'b0;
        hold_left   <= pick_gap();
      end else begin
        ph_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on input handshake, check on output handshake
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_fire <= 1'b0;
    end else begin
      sample_fire <= smp_if.valid && smp_if.ready;
      if (smp_if.valid && smp_if.ready) begin
        due_word.phase = expected_phase(smp_if.real_part, smp_if.imag_part, offset_now);
        due_word.last  = smp_if.last_in;
        phase_due.push_back(due_word);
      end
      if (ph_if.valid && ph_if.ready) begin
        got_word.phase = ph_if.phase;
        got_word.last  = ph_if.last_out;
        if (phase_due.size() == 0) begin
          note_mismatch($sformatf("unexpected word: phase %0d last %0b",
                                  got_word.phase, got_word.last));
        end else begin
          due_word = phase_due.pop_front();
          if (got_word.phase !== due_word.phase)
            note_mismatch($sformatf("phase: got %0d, want %0d",
                                    got_word.phase, due_word.phase));
          if (got_word.last !== due_word.last)
            note_mismatch($sformatf("last_out: got %0b, want %0b",
                                    got_word.last, due_word.last));
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (smp_if.valid && smp_if.ready) || (ph_if.valid && ph_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    smp_if.valid     = 1'b0;
    smp_if.real_part = '0;
    smp_if.imag_part = '0;
    smp_if.last_in   = 1'b0;
    ph_if.ready      = 1'b0;
    offset_now       = '0;
    no_idle          = 1'b0;
    send_gap         = 0;
    hold_left        = 0;
    press_requests   = 0;
    press_served     = 0;
    quiet_cycles     = 0;
    fail_count       = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners at the reset offset: origin, both axes, extremes, near +-pi
    push_sample(0, 0, 1'b0);
    push_sample(32767, 0, 1'b1);
    push_sample(-32768, 0, 1'b0);
    push_sample(-1, 0, 1'b0);
    push_sample(-5, 0, 1'b1);
    push_sample(1, 0, 1'b0);
    push_sample(0, 32767, 1'b0);
    push_sample(0, -32768, 1'b1);
    push_sample(0, 1, 1'b0);
    push_sample(0, -1, 1'b0);
    push_sample(32767, 32767, 1'b0);
    push_sample(-32768, -32768, 1'b1);
    push_sample(-32768, 32767, 1'b0);
    push_sample(32767, -32768, 1'b0);
    push_sample(-32768, -1, 1'b1);
    push_sample(-32768, 1, 1'b0);
    push_sample(-1, -1, 1'b0);
    push_sample(1, 1, 1'b1);
    push_sample(-1, 1, 1'b0);
    push_sample(1, -1, 1'b1);

    run_phase(25736, 250, 1'b0, 1'b0);
    run_phase(-25736, 250, 1'b1, 1'b0);
    // offsets beyond a half turn are added as they stand
    run_phase(32767, 200, 1'b0, 1'b1);
    run_phase(-32768, 150, 1'b0, 1'b0);
    for (int p = 0; p < 4; p++)
      run_phase(int'($urandom_range(0, 51472)) - 25736, 100, 1'b0, p == 2);
    run_phase(0, 200, 1'b0, 1'b0);

    settle();
    if (phase_due.size() != 0)
      note_mismatch($sformatf("%0d words never arrived", phase_due.size()));
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
